@@ rtl/core/fsmk_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the flow shop makespan core.
// No dependencies; imported by the cell, the top level and the checker.
package fsmk_pkg;

    localparam int JOB_W   = 6;
    localparam int MACH_W  = 4;
    localparam int PTIME_W = 16;
    localparam int SPAN_W  = 24;
    localparam int NJOBS_W = 7;
    localparam int NMACH_W = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    localparam logic [SPAN_W-1:0] SPAN_MAX = {SPAN_W{1'b1}};

    typedef enum logic {
        CMD_WRITE = 1'b0,
        CMD_JOB   = 1'b1
    } cmd_t;

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_JOBS     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_MACHINES = 2'd1;

    // One beat moving down the chain of machine cells.
    typedef struct packed {
        logic                valid;
        cmd_t                cmd;
        logic [JOB_W-1:0]    job;
        logic                job_ok;
        logic [MACH_W-1:0]   mach;
        logic [PTIME_W-1:0]  wdata;
        logic [SPAN_W-1:0]   left;
        logic                last;
    } flow_tok_t;

endpackage

@@ rtl/core/flow_shop_makespan_core.sv @@
`timescale 1ns / 1ps
// Channel  | Ports                                                 | Direction
// s_       | s_valid s_ready s_command s_job_index ...proc_time    | in
// m_       | m_valid m_ready m_makespan                            | out
// cfg_     | cfg_valid cfg_ready cfg_index cfg_data                | in
// One beat enters per cycle unless the chain stalls; each beat walks a chain of MAX_MACHINES
// cells, each a table read and then a max-plus update, and a makespan is registered on m_
// once the last job of its sequence leaves the chain. Reset clears the completion row, the
// job counter and output valid; the time table is undefined until written. The chain stalls
// only while a makespan reaches the end of it and the previous one is still held on m_.
// cfg_ready is always high. Top level; depends on fsmk_pkg and fsmk_cell.
module flow_shop_makespan_core import fsmk_pkg::*; #(
    parameter int MAX_JOBS     = 64,
    parameter int MAX_MACHINES = 16,
    parameter int TIME_BITS    = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_command,
    input  logic [JOB_W-1:0]      s_job_index,
    input  logic [MACH_W-1:0]     s_machine_index,
    input  logic [PTIME_W-1:0]    s_proc_time,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [SPAN_W-1:0]     m_makespan,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [NJOBS_W-1:0] num_jobs_reg;
    logic [NMACH_W-1:0] num_machines_reg;
    logic [NJOBS_W-1:0] jobs_seen_reg;
    logic [NJOBS_W-1:0] jobs_seen_next;
    logic [NJOBS_W-1:0] seen_inc;
    logic [NJOBS_W-1:0] nj;
    logic [NMACH_W-1:0] nm;
    logic               out_valid_reg;
    logic [SPAN_W-1:0]  out_span_reg;
    logic               en;
    logic               tail_result;
    logic               is_job;
    logic               seq_last;
    logic [MAX_MACHINES-1:0] active;
    flow_tok_t          head_tok;
    flow_tok_t          chain [MAX_MACHINES+1];

    assign nj = (num_jobs_reg == '0) ? NJOBS_W'(1) :
                (32'(num_jobs_reg) > MAX_JOBS) ? NJOBS_W'(MAX_JOBS) : num_jobs_reg;
    assign nm = (num_machines_reg == '0) ? NMACH_W'(1) :
                (32'(num_machines_reg) > MAX_MACHINES) ? NMACH_W'(MAX_MACHINES)
                                                       : num_machines_reg;

    assign tail_result = chain[MAX_MACHINES].valid && (chain[MAX_MACHINES].cmd == CMD_JOB)
                         && chain[MAX_MACHINES].last;
    assign en          = !(tail_result && out_valid_reg && !m_ready);
    assign s_ready     = en;
    assign cfg_ready   = 1'b1;

    assign is_job   = (s_command == CMD_JOB);
    assign seen_inc = jobs_seen_reg + NJOBS_W'(1);
    assign seq_last = (seen_inc >= nj);

    always_comb begin
        jobs_seen_next = jobs_seen_reg;
        if (s_valid && en && is_job) begin
            jobs_seen_next = seq_last ? '0 : seen_inc;
        end
    end

    always_comb begin
        head_tok        = '0;
        head_tok.valid  = s_valid;
        head_tok.cmd    = cmd_t'(s_command);
        head_tok.job    = s_job_index;
        head_tok.job_ok = (32'(s_job_index) < MAX_JOBS);
        head_tok.mach   = s_machine_index;
        head_tok.wdata  = s_proc_time;
        head_tok.left   = '0;
        head_tok.last   = is_job && seq_last;
    end

    assign chain[0] = head_tok;

    for (genvar m = 0; m < MAX_MACHINES; m++) begin : g_cell
        assign active[m] = (m < int'(nm));
        fsmk_cell #(
            .CELL_IDX  (m),
            .MAX_JOBS  (MAX_JOBS),
            .TIME_BITS (TIME_BITS)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .active  (active[m]),
            .in_tok  (chain[m]),
            .out_tok (chain[m+1])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_jobs_reg     <= NJOBS_W'(64);
            num_machines_reg <= NMACH_W'(16);
            jobs_seen_reg    <= '0;
            out_valid_reg    <= 1'b0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_NUM_JOBS:     num_jobs_reg     <= cfg_data[NJOBS_W-1:0];
                    CFG_NUM_MACHINES: num_machines_reg <= cfg_data[NMACH_W-1:0];
                    default: ;
                endcase
            end
            jobs_seen_reg <= jobs_seen_next;
            if (en && tail_result) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en && tail_result) begin
            out_span_reg <= chain[MAX_MACHINES].left;
        end
    end

    assign m_valid    = out_valid_reg;
    assign m_makespan = out_span_reg;

endmodule

@@ rtl/core/fsmk_cell.sv @@
`timescale 1ns / 1ps
// One machine cell: its column of the time table, its completion time and two stages.
// Depends on fsmk_pkg.
module fsmk_cell import fsmk_pkg::*; #(
    parameter int CELL_IDX  = 0,
    parameter int MAX_JOBS  = 64,
    parameter int TIME_BITS = 16
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      en,
    input  logic      active,
    input  flow_tok_t in_tok,
    output flow_tok_t out_tok
);

    localparam int JW    = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
    localparam int SUM_W = ((TIME_BITS > SPAN_W) ? TIME_BITS : SPAN_W) + 1;

    logic [TIME_BITS-1:0] mem [MAX_JOBS];
    logic [TIME_BITS-1:0] rd_reg;
    flow_tok_t            a_reg;
    flow_tok_t            out_reg;
    flow_tok_t            out_next;
    logic [SPAN_W-1:0]    row_reg;
    logic [SPAN_W-1:0]    row_next;
    logic [SPAN_W-1:0]    mx;
    logic [TIME_BITS-1:0] ptime;
    logic [SUM_W-1:0]     sum;
    logic [SPAN_W-1:0]    sat;
    logic [JW-1:0]        addr;
    logic                 wr_hit;
    logic                 job_tok;
    logic                 job_here;

    assign addr   = JW'(in_tok.job);
    assign wr_hit = in_tok.valid && (in_tok.cmd == CMD_WRITE) && in_tok.job_ok
                    && (int'(in_tok.mach) == CELL_IDX);

    always_ff @(posedge aclk) begin
        if (en) begin
            if (wr_hit) begin
                mem[addr] <= TIME_BITS'(in_tok.wdata);
            end
            rd_reg <= mem[addr];
        end
    end

    assign job_tok  = a_reg.valid && (a_reg.cmd == CMD_JOB);
    assign job_here = job_tok && active;
    assign ptime    = a_reg.job_ok ? rd_reg : '0;
    assign mx       = (row_reg > a_reg.left) ? row_reg : a_reg.left;
    assign sum      = SUM_W'(mx) + SUM_W'(ptime);
    assign sat      = (sum > SUM_W'(SPAN_MAX)) ? SPAN_MAX : SPAN_W'(sum);

    always_comb begin
        out_next = a_reg;
        row_next = row_reg;
        if (job_here) begin
            out_next.left = sat;
            row_next      = sat;
        end
        // clear the row at the end of a sequence, active or not
        if (job_tok && a_reg.last) begin
            row_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_reg   <= '0;
            out_reg <= '0;
            row_reg <= '0;
        end else if (en) begin
            a_reg   <= in_tok;
            out_reg <= out_next;
            row_reg <= row_next;
        end
    end

    assign out_tok = out_reg;

endmodule

@@ rtl/core/fsmk_checker.sv @@
`timescale 1ns / 1ps
// Port-level checks for the flow shop makespan core, bound to the top level.
// Depends on fsmk_pkg.
module fsmk_checker import fsmk_pkg::*; (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_valid,
    input logic                  s_ready,
    input logic                  s_command,
    input logic [JOB_W-1:0]      s_job_index,
    input logic [MACH_W-1:0]     s_machine_index,
    input logic [PTIME_W-1:0]    s_proc_time,
    input logic                  m_valid,
    input logic                  m_ready,
    input logic [SPAN_W-1:0]     m_makespan,
    input logic                  cfg_valid,
    input logic                  cfg_ready
);

    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid
            && $stable({s_command, s_job_index, s_machine_index, s_proc_time}))
        else $error("input beat dropped or changed while stalled");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_makespan))
        else $error("result beat dropped or changed while stalled");

    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled without a held result beat");

    a_reset_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result beat valid right after reset");

    a_cfg_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid |-> cfg_ready)
        else $error("configuration port not ready");

endmodule

bind flow_shop_makespan_core fsmk_checker u_fsmk_checker (.*);
